/* src/unicode_escape_to_utf8_defines.svh */
// Assertion macros used by the escape decoder top level.
`ifndef UNICODE_ESCAPE_TO_UTF8_DEFINES_SVH
`define UNICODE_ESCAPE_TO_UTF8_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UE8_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UE8_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/ue8_pkg.sv */
// Types and constants shared by the escape decoder modules.
`timescale 1ns / 1ps

package ue8_pkg;

   localparam int MAX_RESULTS = 5;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] BSLASH   = 8'h5C;
   localparam logic [7:0] LETTER_U = 8'h75;

   localparam logic [15:0] ONE_BYTE_MAX = 16'h007F;
   localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;
   localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
   localparam logic [7:0]  UTF8_CONT    = 8'h80;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // Group of output bytes produced by one input transfer.
   typedef struct packed {
      logic [2:0]                   count;
      logic                         last;
      logic [MAX_RESULTS-1:0][7:0]  bytes;
   } rec_type;

   typedef struct packed {
      logic escape_idle;
   } front_status_type;

endpackage

/* src/ue8_front.sv */
// Front end: tracks escape sequences and turns each input byte into a byte group.
`timescale 1ns / 1ps

module ue8_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  ue8_pkg::req_type          req,
   output ue8_pkg::rec_type          rec,
   output logic                      rec_push,
   output ue8_pkg::front_status_type status
);
   import ue8_pkg::*;

   typedef enum logic [5:0] {
      PH_IDLE = 6'b000001,
      PH_BSL  = 6'b000010,
      PH_U    = 6'b000100,
      PH_H1   = 6'b001000,
      PH_H2   = 6'b010000,
      PH_H3   = 6'b100000
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [2:0][7:0]  pend_ff, pend_in;
   logic [15:0]      code_ff, code_in;
   logic             run_ff, run_in;
   rec_type          rec_c;
   logic [4:0]       hex_c;
   logic [15:0]      ext_c;

   // Returns {is_hex, digit}.
   function automatic logic [4:0] hex_decode(logic [7:0] b);
      logic [7:0] t;
      logic [4:0] r;
      t = 8'h00;
      r = 5'b0;
      if (b inside {[8'h30:8'h39]}) begin
         r = {1'b1, b[3:0]};
      end else if (b inside {[8'h61:8'h66]}) begin
         t = b - 8'h57;
         r = {1'b1, t[3:0]};
      end else if (b inside {[8'h41:8'h46]}) begin
         t = b - 8'h37;
         r = {1'b1, t[3:0]};
      end
      return r;
   endfunction

   function automatic rec_type append(rec_type r, logic [7:0] b);
      rec_type o;
      o = r;
      if (o.count < 3'(MAX_RESULTS)) begin
         o.bytes[o.count] = b;
         o.count          = o.count + 3'd1;
      end
      return o;
   endfunction

   assign hex_c = hex_decode(req.in_byte);
   // The hex run only grows while it is unbroken.
   assign ext_c = (run_ff && hex_c[4]) ? {code_ff[11:0], hex_c[3:0]} : code_ff;

   always_comb begin
      phase_in = phase_ff;
      pend_in  = pend_ff;
      code_in  = code_ff;
      run_in   = run_ff;
      rec_c    = '0;
      rec_c.last = req.in_last;

      case (phase_ff)
         PH_BSL: begin
            if (req.in_byte == LETTER_U) begin
               phase_in = PH_U;
            end else begin
               rec_c = append(rec_c, BSLASH);
               if (req.in_byte == BSLASH) begin
                  phase_in = PH_BSL;
               end else begin
                  rec_c    = append(rec_c, req.in_byte);
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_U: begin
            if (hex_c[4]) begin
               pend_in[0] = req.in_byte;
               code_in    = {12'h000, hex_c[3:0]};
               run_in     = 1'b1;
               phase_in   = PH_H1;
            end else begin
               rec_c = append(rec_c, BSLASH);
               rec_c = append(rec_c, LETTER_U);
               if (req.in_byte == BSLASH) begin
                  phase_in = PH_BSL;
               end else begin
                  rec_c    = append(rec_c, req.in_byte);
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_H1: begin
            pend_in[1] = req.in_byte;
            code_in    = ext_c;
            run_in     = run_ff & hex_c[4];
            phase_in   = PH_H2;
         end
         PH_H2: begin
            pend_in[2] = req.in_byte;
            code_in    = ext_c;
            run_in     = run_ff & hex_c[4];
            phase_in   = PH_H3;
         end
         PH_H3: begin
            if (ext_c <= ONE_BYTE_MAX) begin
               rec_c = append(rec_c, ext_c[7:0]);
            end else if (ext_c <= TWO_BYTE_MAX) begin
               rec_c = append(rec_c, UTF8_LEAD2 | {3'b000, ext_c[10:6]});
               rec_c = append(rec_c, UTF8_CONT | {2'b00, ext_c[5:0]});
            end else begin
               rec_c = append(rec_c, UTF8_LEAD3 | {4'h0, ext_c[15:12]});
               rec_c = append(rec_c, UTF8_CONT | {2'b00, ext_c[11:6]});
               rec_c = append(rec_c, UTF8_CONT | {2'b00, ext_c[5:0]});
            end
            phase_in = PH_IDLE;
            code_in  = 16'h0000;
            run_in   = 1'b0;
         end
         default: begin
            if (req.in_byte == BSLASH) begin
               phase_in = PH_BSL;
            end else begin
               rec_c    = append(rec_c, req.in_byte);
               phase_in = PH_IDLE;
            end
         end
      endcase

      // At the end of a string, whatever is still held goes out literally.
      if (req.in_last) begin
         case (phase_in)
            PH_BSL: begin
               rec_c = append(rec_c, BSLASH);
            end
            PH_U: begin
               rec_c = append(rec_c, BSLASH);
               rec_c = append(rec_c, LETTER_U);
            end
            PH_H1: begin
               rec_c = append(rec_c, BSLASH);
               rec_c = append(rec_c, LETTER_U);
               rec_c = append(rec_c, pend_in[0]);
            end
            PH_H2: begin
               rec_c = append(rec_c, BSLASH);
               rec_c = append(rec_c, LETTER_U);
               rec_c = append(rec_c, pend_in[0]);
               rec_c = append(rec_c, pend_in[1]);
            end
            PH_H3: begin
               rec_c = append(rec_c, BSLASH);
               rec_c = append(rec_c, LETTER_U);
               rec_c = append(rec_c, pend_in[0]);
               rec_c = append(rec_c, pend_in[1]);
               rec_c = append(rec_c, pend_in[2]);
            end
            default: begin
            end
         endcase
         phase_in = PH_IDLE;
         code_in  = 16'h0000;
         run_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         code_ff  <= 16'h0000;
         run_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         code_ff  <= code_in;
         run_ff   <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
   end

   assign rec                = rec_c;
   assign rec_push           = accept && (rec_c.count != 3'd0);
   assign status.escape_idle = (phase_ff == PH_IDLE);

endmodule

/* src/ue8_queue.sv */
// Small queue of byte groups between the front end and the serializer.
`timescale 1ns / 1ps

module ue8_queue #(
   parameter int Depth = ue8_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ue8_pkg::rec_type push_data,
   output logic             full,
   input  logic             pop,
   output ue8_pkg::rec_type pop_data,
   output logic             empty
);
   import ue8_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   rec_type             slots_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full     = (count_ff == CntW'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/ue8_back.sv */
// Back end: walks each byte group and feeds the output register one byte a cycle while it is empty or popped.
`timescale 1ns / 1ps

module ue8_back (
   input  logic             clock,
   input  logic             reset,
   input  ue8_pkg::rec_type rec,
   input  logic             rec_valid,
   output logic             rec_pop,
   output ue8_pkg::rsp_type rsp,
   output logic             rsp_empty,
   input  logic             rsp_pop
);
   import ue8_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       load;
   logic       at_end;

   assign load   = rec_valid && (!valid_ff || rsp_pop);
   assign at_end = (idx_ff == rec.count - 3'd1);

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (load) begin
         rsp_in.out_byte = rec.bytes[idx_ff];
         rsp_in.out_last = rec.last && at_end;
         valid_in        = 1'b1;
         idx_in          = at_end ? 3'd0 : idx_ff + 3'd1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rec_pop   = load && at_end;
   assign rsp       = rsp_ff;
   assign rsp_empty = !valid_ff;

endmodule

/* src/unicode_escape_to_utf8.sv */
// Top level of the backslash-u escape to UTF-8 stream decoder.
`timescale 1ns / 1ps
`include "unicode_escape_to_utf8_defines.svh"

// The block decodes a string stream one byte at a time. Input bytes arrive on
// the req_ side as a queue: a transfer happens at a clock edge where req_push
// is high and req_full is low, and req_data.in_last marks the final byte of a
// string. Decoded UTF-8 bytes leave on the rsp_ side: while rsp_empty is low
// the oldest byte sits on rsp_data, and a transfer happens when rsp_pop is high.
// A front end tracks escapes and turns each input byte into a group of zero to
// five output bytes, a short queue of groups follows, and a serializer hands
// out one byte per cycle through an output register whenever that register is
// empty or being popped. One input byte is taken every cycle while the group
// queue has room. The first output byte of a group passes through the group
// queue and then the output register before it reaches rsp_data. The output
// side moves one byte per cycle while rsp_pop is high; the group queue depth
// sets how many groups input can still push while output is stalled. When
// rsp_pop stays low, the output register holds, the queue fills and req_full
// rises. Synchronous reset empties the queue and the output register and drops
// any escape in progress.

module unicode_escape_to_utf8 #(
   parameter int QueueDepth = ue8_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  ue8_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output ue8_pkg::rsp_type rsp_data
);
   import ue8_pkg::*;

   logic             fire;
   rec_type          front_rec;
   logic             q_push;
   logic             q_full;
   rec_type          q_head;
   logic             q_empty;
   logic             q_pop;
   front_status_type front_status;

   // An input transfer is taken whenever the group queue has room.
   assign fire     = req_push && !q_full;
   assign req_full = q_full;

   ue8_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (fire),
      .req      (req_data),
      .rec      (front_rec),
      .rec_push (q_push),
      .status   (front_status)
   );

   ue8_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_rec),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_head),
      .empty     (q_empty)
   );

   ue8_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec       (q_head),
      .rec_valid (!q_empty),
      .rec_pop   (q_pop),
      .rsp       (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   // The end of a string always flushes the escape tracker.
   `UE8_ASSERT_NEXT(a_last_clears_escape, clock, reset, fire && req_data.in_last,
                    front_status.escape_idle, "escape still pending after last byte")
   // The end of a string always yields at least one output byte.
   `UE8_ASSERT_SAME(a_last_pushes_group, clock, reset, fire && req_data.in_last,
                    q_push, "last byte produced no output group")
   // The serializer never retires a group that is not there.
   `UE8_ASSERT_SAME(a_pop_needs_group, clock, reset, q_pop, !q_empty,
                    "group retired from empty queue")

endmodule
